// File: hdl/clr_pkg.sv
// shared types, constants and helpers for the clipped line rasteriser
// no dependencies
package clr_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int PIX_W       = COORD_WIDTH + 1;
	localparam int CLIP_W      = 32;
	localparam int OPD_W       = CLIP_W + 1;
	localparam int PROD_W      = 2 * OPD_W;
	localparam int NUM_W       = 63;
	localparam int CNT_W       = 6;
	localparam int TERM_W      = 20;
	localparam int DIM_W       = 13;
	localparam int COLOR_W     = 32;
	localparam int IN_DATA_W   = ((4 * COORD_WIDTH + COLOR_W + 7) / 8) * 8;
	localparam int OUT_FLD_W   = 2 * PIX_W + COLOR_W + 1;
	localparam int OUT_DATA_W  = ((OUT_FLD_W + 7) / 8) * 8;

	localparam logic signed [CLIP_W-1:0] CLIP_LIM = CLIP_W'(1) <<< 30;
	localparam logic signed [CLIP_W-1:0] PIX_MAX  = (CLIP_W'(1) <<< COORD_WIDTH) - CLIP_W'(1);
	localparam logic signed [CLIP_W-1:0] PIX_MIN  = -(CLIP_W'(1) <<< COORD_WIDTH);

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	localparam logic [1:0] ST_PIXEL  = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_IDLE   = 2'd2;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
	localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

	// octant codes
	localparam logic [1:0] OCT_XUP = 2'd0;
	localparam logic [1:0] OCT_YUP = 2'd1;
	localparam logic [1:0] OCT_XDN = 2'd2;
	localparam logic [1:0] OCT_YDN = 2'd3;

	// clip edge sequence
	localparam logic [2:0] CE_BOT1 = 3'd0;
	localparam logic [2:0] CE_BOT2 = 3'd1;
	localparam logic [2:0] CE_LFT1 = 3'd2;
	localparam logic [2:0] CE_LFT2 = 3'd3;
	localparam logic [2:0] CE_RGT1 = 3'd4;
	localparam logic [2:0] CE_RGT2 = 3'd5;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CHECK = 7'b0000010,
		S_MUL   = 7'b0000100,
		S_DIV   = 7'b0001000,
		S_FIX   = 7'b0010000,
		S_ORDER = 7'b0100000,
		S_SETUP = 7'b1000000
	} state_t;

	function automatic logic pix_in_frame(input logic signed [PIX_W-1:0] x,
			input logic signed [PIX_W-1:0] y, input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h);
		logic xin, yin;
		xin = !x[PIX_W-1] && ({1'b0, x[PIX_W-2:0]} < PIX_W'(w));
		yin = !y[PIX_W-1] && ({1'b0, y[PIX_W-2:0]} < PIX_W'(h));
		return xin && yin;
	endfunction

	function automatic logic signed [OPD_W-1:0] ext(input logic signed [CLIP_W-1:0] v);
		return {v[CLIP_W-1], v};
	endfunction

endpackage

// File: hdl/clipped_line_rasterizer.sv
// clipped line rasteriser: clips a line to the frame, then steps it pixel by pixel
// depends on clr_pkg
// a step transaction gives its pixel in the cycle after acceptance, one per cycle while
// the output is not stalled. a start transaction that is rejected answers in the cycle
// after acceptance; otherwise the six clip edges are checked in turn, and each edge that
// clips goes through one multiply, a 63-step bit-serial divide and one fix-up; then the
// endpoints are ordered and the line is set up. one multiplier and one divider are shared
// by all edges. reset clears control state and restores the frame size to 640 by 480.
module clipped_line_rasterizer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// start_x, start_y, end_x, end_y, pen_color
	input  logic [clr_pkg::IN_DATA_W-1:0] s_tdata,
	// cmd
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// pixel_x, pixel_y, pixel_color, in_frame, zero pad
	output logic [clr_pkg::OUT_DATA_W-1:0] m_tdata,
	// status
	output logic [1:0]                    m_tuser,
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [clr_pkg::DIM_W-1:0]     cfg_data
);
	import clr_pkg::*;

	state_t state_q;
	logic [DIM_W-1:0] width_q, height_q;

	logic line_active_q;
	logic signed [PIX_W-1:0] cur_x_q, cur_y_q, stop_x_q, stop_y_q;
	logic signed [TERM_W-1:0] dterm_q, inc_s_q, inc_d_q;
	logic [1:0] octant_q;
	logic [COLOR_W-1:0] color_q;

	logic signed [CLIP_W-1:0] x1_q, y1_q, x2_q, y2_q;
	logic [2:0] idx_q;
	logic [NUM_W-1:0] num_q;
	logic [OPD_W-1:0] rem_q;
	logic [CLIP_W-1:0] den_q;
	logic qneg_q, dzero_q;
	logic [CNT_W-1:0] cnt_q;

	logic out_valid_q;
	logic [1:0] o_status_q;
	logic signed [PIX_W-1:0] o_x_q, o_y_q;
	logic [COLOR_W-1:0] o_color_q;
	logic o_inf_q, o_last_q;

	logic in_acc, out_free, out_load;
	logic [COORD_WIDTH-1:0] in_x1, in_y1, in_x2, in_y2;
	logic [COLOR_W-1:0] in_color;
	logic reject;

	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && out_free;
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign in_x1    = s_tdata[COORD_WIDTH-1:0];
	assign in_y1    = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
	assign in_x2    = s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
	assign in_y2    = s_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH];
	assign in_color = s_tdata[4*COORD_WIDTH+COLOR_W-1:4*COORD_WIDTH];

	// endpoints are unsigned, so only the far edges can hold both
	assign reject = ((COORD_WIDTH+1)'(in_y1) >= (COORD_WIDTH+1)'(height_q)
			&& (COORD_WIDTH+1)'(in_y2) >= (COORD_WIDTH+1)'(height_q))
		|| ((COORD_WIDTH+1)'(in_x1) >= (COORD_WIDTH+1)'(width_q)
			&& (COORD_WIDTH+1)'(in_x2) >= (COORD_WIDTH+1)'(width_q));

	// a result is loaded at once unless a start goes off to clip; a clipped start loads from setup
	assign out_load = (in_acc && !(s_tuser == CMD_START && !reject)) || (state_q == S_SETUP);

	// clip operand selection
	logic signed [OPD_W-1:0] hs, ws, mul_a, mul_b, div_d, dxs, dys;
	logic signed [CLIP_W-1:0] base;
	logic do_sub, clip_cond;

	assign hs  = OPD_W'(height_q);
	assign ws  = OPD_W'(width_q);
	assign dxs = ext(x1_q) - ext(x2_q);
	assign dys = ext(y1_q) - ext(y2_q);

	always_comb begin
		mul_a = '0; mul_b = dys; div_d = -dxs; base = y1_q; do_sub = 1'b1; clip_cond = 1'b0;
		unique case (idx_q)
			CE_BOT1: begin
				mul_a = hs - ext(y1_q); mul_b = dxs; div_d = -dys; base = x1_q;
				clip_cond = ext(y1_q) >= hs;
			end
			CE_BOT2: begin
				mul_a = hs - ext(y2_q); mul_b = dxs; div_d = -dys; base = x2_q;
				clip_cond = ext(y2_q) >= hs;
			end
			CE_LFT1: begin
				mul_a = ext(x1_q); do_sub = 1'b0; clip_cond = x1_q < 0;
			end
			CE_LFT2: begin
				mul_a = ext(x2_q); base = y2_q; do_sub = 1'b0; clip_cond = x2_q < 0;
			end
			CE_RGT1: begin
				mul_a = ws - ext(x1_q); clip_cond = ext(x1_q) >= ws;
			end
			CE_RGT2: begin
				mul_a = ws - ext(x2_q); base = y2_q; clip_cond = ext(x2_q) >= ws;
			end
			default: ;
		endcase
	end

	logic signed [PROD_W-1:0] prod, prod_mag;
	logic signed [OPD_W-1:0] d_mag;
	assign prod     = mul_a * mul_b;
	assign prod_mag = prod[PROD_W-1] ? -prod : prod;
	assign d_mag    = div_d[OPD_W-1] ? -div_d : div_d;

	// one restoring divide step
	logic [OPD_W-1:0] trial;
	logic trial_ge;
	assign trial    = {rem_q[OPD_W-2:0], num_q[NUM_W-1]};
	assign trial_ge = trial >= OPD_W'(den_q);

	// fix-up: sign, offset and saturation
	logic signed [NUM_W:0] qv, rsum;
	logic signed [CLIP_W-1:0] clip_r;
	always_comb begin
		qv = dzero_q ? '0 : (qneg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q}));
		rsum = do_sub ? ((NUM_W+1)'(base) - qv) : ((NUM_W+1)'(base) + qv);
		if (rsum > (NUM_W+1)'(CLIP_LIM))
			clip_r = CLIP_LIM;
		else if (rsum < -(NUM_W+1)'(CLIP_LIM))
			clip_r = -CLIP_LIM;
		else
			clip_r = rsum[CLIP_W-1:0];
	end

	function automatic logic signed [CLIP_W-1:0] pclamp(input logic signed [CLIP_W-1:0] v);
		return v < PIX_MIN ? PIX_MIN : (v > PIX_MAX ? PIX_MAX : v);
	endfunction

	// line setup from ordered endpoints
	logic signed [PIX_W-1:0] sx1, sy1, sx2, sy2, su_cy, su_sy;
	logic signed [PIX_W:0] dx, dy;
	logic signed [TERM_W-1:0] su_d, su_s, su_g;
	logic [1:0] su_oct;
	logic su_last;
	always_comb begin
		sx1 = x1_q[PIX_W-1:0]; sy1 = y1_q[PIX_W-1:0];
		sx2 = x2_q[PIX_W-1:0]; sy2 = y2_q[PIX_W-1:0];
		dx = (PIX_W+1)'(sx2) - (PIX_W+1)'(sx1);
		dy = (PIX_W+1)'(sy2) - (PIX_W+1)'(sy1);
		su_cy = sy1; su_sy = sy2;
		su_d = '0; su_s = '0; su_g = '0; su_oct = OCT_XUP;
		if (dx == 0) begin
			su_oct = OCT_YUP;
			su_cy = (sy1 < sy2) ? sy1 : sy2;
			su_sy = (sy1 < sy2) ? sy2 : sy1;
		end else if (dy == 0) begin
			su_oct = OCT_XUP;
		end else if (dy > 0 && dy <= dx) begin
			su_oct = OCT_XUP;
			su_d = TERM_W'(2 * dy - dx); su_s = TERM_W'(2 * dy); su_g = TERM_W'(2 * (dy - dx));
		end else if (dy > 0) begin
			su_oct = OCT_YUP;
			su_d = TERM_W'(2 * dx - dy); su_s = TERM_W'(2 * dx); su_g = TERM_W'(2 * (dx - dy));
		end else if (-dy <= dx) begin
			su_oct = OCT_XDN;
			su_d = TERM_W'(-2 * dy - dx); su_s = TERM_W'(-2 * dy);
			su_g = TERM_W'(-2 * (dy + dx));
		end else begin
			su_oct = OCT_YDN;
			su_d = TERM_W'(2 * dx + dy); su_s = TERM_W'(2 * dx); su_g = TERM_W'(2 * (dx + dy));
		end
		su_last = (su_oct == OCT_YUP || su_oct == OCT_YDN) ? (su_cy == su_sy) : (sx1 == sx2);
	end

	// single pixel step
	logic diag, st_last;
	logic signed [PIX_W-1:0] st_x, st_y;
	logic signed [TERM_W-1:0] st_d;
	always_comb begin
		diag = dterm_q > 0;
		st_d = dterm_q + (diag ? inc_d_q : inc_s_q);
		st_x = cur_x_q; st_y = cur_y_q;
		unique case (octant_q)
			OCT_YUP: begin st_y = cur_y_q + 1'b1; if (diag) st_x = cur_x_q + 1'b1; end
			OCT_XDN: begin st_x = cur_x_q + 1'b1; if (diag) st_y = cur_y_q - 1'b1; end
			OCT_YDN: begin st_y = cur_y_q - 1'b1; if (diag) st_x = cur_x_q + 1'b1; end
			default: begin st_x = cur_x_q + 1'b1; if (diag) st_y = cur_y_q + 1'b1; end
		endcase
		st_last = (octant_q == OCT_YUP || octant_q == OCT_YDN) ? (st_y == stop_y_q)
			: (st_x == stop_x_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			width_q <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			line_active_q <= 1'b0;
			cur_x_q <= '0; cur_y_q <= '0; stop_x_q <= '0; stop_y_q <= '0;
			dterm_q <= '0; inc_s_q <= '0; inc_d_q <= '0;
			octant_q <= OCT_XUP;
			color_q <= '0;
			out_valid_q <= 1'b0;
			idx_q <= CE_BOT1;
			cnt_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_WIDTH:  width_q <= cfg_data;
					CFG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tvalid && m_tready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (s_tuser == CMD_START) begin
							color_q <= in_color;
							line_active_q <= 1'b0;
							if (reject) begin
								o_status_q <= ST_REJECT; o_x_q <= '0; o_y_q <= '0;
								o_color_q <= '0; o_inf_q <= 1'b0; o_last_q <= 1'b1;
							end else begin
								x1_q <= CLIP_W'(in_x1); y1_q <= CLIP_W'(in_y1);
								x2_q <= CLIP_W'(in_x2); y2_q <= CLIP_W'(in_y2);
								idx_q <= CE_BOT1;
								state_q <= S_CHECK;
							end
						end else if (!line_active_q) begin
							o_status_q <= ST_IDLE; o_x_q <= '0; o_y_q <= '0;
							o_color_q <= '0; o_inf_q <= 1'b0; o_last_q <= 1'b0;
						end else begin
							cur_x_q <= st_x; cur_y_q <= st_y; dterm_q <= st_d;
							line_active_q <= !st_last;
							o_status_q <= ST_PIXEL; o_x_q <= st_x; o_y_q <= st_y;
							o_color_q <= color_q;
							o_inf_q <= pix_in_frame(st_x, st_y, width_q, height_q);
							o_last_q <= st_last;
						end
					end
				end
				S_CHECK: begin
					if (clip_cond)
						state_q <= S_MUL;
					else if (idx_q == CE_RGT2)
						state_q <= S_ORDER;
					else
						idx_q <= idx_q + 1'b1;
				end
				S_MUL: begin
					num_q <= prod_mag[NUM_W-1:0];
					rem_q <= '0;
					den_q <= d_mag[CLIP_W-1:0];
					dzero_q <= div_d == 0;
					qneg_q <= prod[PROD_W-1] ^ div_d[OPD_W-1];
					cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= trial_ge ? trial - OPD_W'(den_q) : trial;
					num_q <= {num_q[NUM_W-2:0], trial_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NUM_W - 1))
						state_q <= S_FIX;
				end
				S_FIX: begin
					unique case (idx_q)
						CE_BOT1: begin x1_q <= clip_r; y1_q <= CLIP_W'(height_q) - 1; end
						CE_BOT2: begin x2_q <= clip_r; y2_q <= CLIP_W'(height_q) - 1; end
						CE_LFT1: begin y1_q <= clip_r; x1_q <= '0; end
						CE_LFT2: begin y2_q <= clip_r; x2_q <= '0; end
						CE_RGT1: begin y1_q <= clip_r; x1_q <= CLIP_W'(width_q) - 1; end
						default: begin y2_q <= clip_r; x2_q <= CLIP_W'(width_q) - 1; end
					endcase
					if (idx_q == CE_RGT2)
						state_q <= S_ORDER;
					else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_CHECK;
					end
				end
				S_ORDER: begin
					if (x1_q > x2_q) begin
						x1_q <= pclamp(x2_q); y1_q <= pclamp(y2_q);
						x2_q <= pclamp(x1_q); y2_q <= pclamp(y1_q);
					end else begin
						x1_q <= pclamp(x1_q); y1_q <= pclamp(y1_q);
						x2_q <= pclamp(x2_q); y2_q <= pclamp(y2_q);
					end
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					cur_x_q <= sx1; cur_y_q <= su_cy; stop_x_q <= sx2; stop_y_q <= su_sy;
					dterm_q <= su_d; inc_s_q <= su_s; inc_d_q <= su_g; octant_q <= su_oct;
					line_active_q <= !su_last;
					o_status_q <= ST_PIXEL; o_x_q <= sx1; o_y_q <= su_cy;
					o_color_q <= color_q;
					o_inf_q <= pix_in_frame(sx1, su_cy, width_q, height_q);
					o_last_q <= su_last;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = o_status_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = OUT_DATA_W'({o_inf_q, o_color_q, o_y_q, o_x_q});

endmodule
